// File: design/nfpes_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfpes_pkg
// Shared types and command codes of the NOR flash program/erase sequencer.
// ----------------------------------------------------------------------------
package nfpes_pkg;

  localparam logic [1:0] OP_READ_ID  = 2'd0;
  localparam logic [1:0] OP_PROGRAM  = 2'd1;
  localparam logic [1:0] OP_ERASE    = 2'd2;
  localparam logic [1:0] OP_RESPONSE = 2'd3;

  localparam logic [1:0] ACT_WRITE = 2'd0;
  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_DONE  = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_TIMEOUT = 2'd1;
  localparam logic [1:0] ST_VERIFY  = 2'd2;
  localparam logic [1:0] ST_BLANK   = 2'd3;

  localparam logic [1:0] CFG_PORT_WIDTH = 2'd0;
  localparam logic [1:0] CFG_BASE       = 2'd1;
  localparam logic [1:0] CFG_PROG_LIMIT = 2'd2;
  localparam logic [1:0] CFG_ERASE_LIMIT = 2'd3;

  localparam logic [1:0] PW_8  = 2'd0;
  localparam logic [1:0] PW_16 = 2'd1;

  localparam logic [31:0] CMD_READ_ID    = 32'h0000_0090;
  localparam logic [31:0] CMD_CLEAR_STAT = 32'h0000_0050;
  localparam logic [31:0] CMD_PROGRAM    = 32'h0000_0040;
  localparam logic [31:0] CMD_ERASE      = 32'h0000_0020;
  localparam logic [31:0] CMD_CONFIRM    = 32'h0000_00D0;
  localparam logic [31:0] CMD_RESET      = 32'h0000_00FF;

  localparam int unsigned STAT_READY_BIT = 7;
  localparam int unsigned CNT_W          = 27;
  localparam int unsigned MAX_RESULTS    = 4;
  localparam int unsigned QUEUE_DEPTH    = 2;

  typedef struct packed {
    logic [1:0]       port_width_code;
    logic [31:0]      base_address;
    logic [CNT_W-1:0] program_poll_limit;
    logic [CNT_W-1:0] erase_poll_limit;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] bus_address;
    logic [31:0] bus_data;
    logic [1:0]  status;
    logic [31:0] chip_ident;
  } res_t;

  typedef struct packed {
    logic [2:0]                   count;
    res_t [MAX_RESULTS-1:0]       res;
  } job_t;

  function automatic res_t mk_res(logic [1:0] act, logic [31:0] addr, logic [31:0] dat,
                                  logic [1:0] st, logic [31:0] id);
    res_t r;
    r.action      = act;
    r.bus_address = addr;
    r.bus_data    = dat;
    r.status      = st;
    r.chip_ident  = id;
    return r;
  endfunction

endpackage

// File: design/nfpes_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfpes_front
// Accepts request and response items, advances the command sequence and
// turns each item into a job of up to four bus operations.
// ----------------------------------------------------------------------------
module nfpes_front #(
  parameter int unsigned MAX_SECTOR_BYTES = 262144
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  nfpes_pkg::cfg_t     cfg_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          opcode_i,
  input  logic [31:0]         address_i,
  input  logic [31:0]         data_i,
  input  logic [18:0]         sector_bytes_i,
  input  logic                full_i,
  output logic                push_o,
  output nfpes_pkg::job_t     job_o
);

  localparam int unsigned BL_W = $clog2(MAX_SECTOR_BYTES + 1);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_ID_VENDOR,
    PH_ID_DEVICE,
    PH_PROG_POLL,
    PH_PROG_VERIFY,
    PH_ERASE_POLL,
    PH_ERASE_CHECK
  } phase_e;

  phase_e                          phase_q, phase_d;
  logic [nfpes_pkg::CNT_W-1:0]     count_q, count_d;
  logic [31:0]                     target_q, target_d;
  logic [31:0]                     expected_q, expected_d;
  logic [BL_W-1:0]                 left_q, left_d;
  logic [15:0]                     vendor_q, vendor_d;
  nfpes_pkg::job_t                 job;

  logic                            take;
  logic [31:0]                     mask;
  logic [2:0]                      nb;
  logic [31:0]                     rd;
  logic [31:0]                     base;

  function automatic logic [nfpes_pkg::CNT_W-1:0] load_count(
      logic [nfpes_pkg::CNT_W-1:0] limit);
    if (limit < nfpes_pkg::CNT_W'(2)) begin
      return nfpes_pkg::CNT_W'(1);
    end
    return limit - nfpes_pkg::CNT_W'(1);
  endfunction

  assign in_stall_o = full_i;
  assign take       = in_valid_i & ~full_i;
  assign base       = cfg_i.base_address;

  always_comb begin
    unique case (cfg_i.port_width_code)
      nfpes_pkg::PW_8: begin
        mask = 32'h0000_00FF;
        nb   = 3'd1;
      end
      nfpes_pkg::PW_16: begin
        mask = 32'h0000_FFFF;
        nb   = 3'd2;
      end
      default: begin
        mask = 32'hFFFF_FFFF;
        nb   = 3'd4;
      end
    endcase
  end

  assign rd = data_i & mask;

  always_comb begin
    logic [nfpes_pkg::CNT_W-1:0] dec;
    logic [31:0]                 sz32;
    logic [BL_W-1:0]             left_sub;
    logic [31:0]                 next_addr;
    logic                        ready;

    dec       = count_q - nfpes_pkg::CNT_W'(1);
    sz32      = 32'(sector_bytes_i);
    left_sub  = (left_q <= BL_W'(nb)) ? '0 : left_q - BL_W'(nb);
    next_addr = target_q + 32'(nb);
    ready     = rd[nfpes_pkg::STAT_READY_BIT];

    phase_d    = phase_q;
    count_d    = count_q;
    target_d   = target_q;
    expected_d = expected_q;
    left_d     = left_q;
    vendor_d   = vendor_q;
    job        = '0;

    if (opcode_i != nfpes_pkg::OP_RESPONSE) begin
      if (phase_q == PH_IDLE) begin
        unique case (opcode_i)
          nfpes_pkg::OP_READ_ID: begin
            job.count  = 3'd2;
            job.res[0] = nfpes_pkg::mk_res(nfpes_pkg::ACT_WRITE, base,
                                           nfpes_pkg::CMD_READ_ID, nfpes_pkg::ST_OK, '0);
            job.res[1] = nfpes_pkg::mk_res(nfpes_pkg::ACT_READ, base, '0,
                                           nfpes_pkg::ST_OK, '0);
            phase_d    = PH_ID_VENDOR;
          end
          nfpes_pkg::OP_PROGRAM: begin
            target_d   = address_i;
            expected_d = rd;
            count_d    = load_count(cfg_i.program_poll_limit);
            job.count  = 3'd4;
            job.res[0] = nfpes_pkg::mk_res(nfpes_pkg::ACT_WRITE, base,
                                           nfpes_pkg::CMD_CLEAR_STAT, nfpes_pkg::ST_OK, '0);
            job.res[1] = nfpes_pkg::mk_res(nfpes_pkg::ACT_WRITE, base,
                                           nfpes_pkg::CMD_PROGRAM, nfpes_pkg::ST_OK, '0);
            job.res[2] = nfpes_pkg::mk_res(nfpes_pkg::ACT_WRITE, address_i, rd,
                                           nfpes_pkg::ST_OK, '0);
            job.res[3] = nfpes_pkg::mk_res(nfpes_pkg::ACT_READ, base, '0,
                                           nfpes_pkg::ST_OK, '0);
            phase_d    = PH_PROG_POLL;
          end
          default: begin
            target_d   = address_i;
            left_d     = (sz32 > 32'(MAX_SECTOR_BYTES)) ? BL_W'(MAX_SECTOR_BYTES)
                                                        : BL_W'(sz32);
            count_d    = load_count(cfg_i.erase_poll_limit);
            job.count  = 3'd4;
            job.res[0] = nfpes_pkg::mk_res(nfpes_pkg::ACT_WRITE, base,
                                           nfpes_pkg::CMD_CLEAR_STAT, nfpes_pkg::ST_OK, '0);
            job.res[1] = nfpes_pkg::mk_res(nfpes_pkg::ACT_WRITE, base,
                                           nfpes_pkg::CMD_ERASE, nfpes_pkg::ST_OK, '0);
            job.res[2] = nfpes_pkg::mk_res(nfpes_pkg::ACT_WRITE, address_i,
                                           nfpes_pkg::CMD_CONFIRM, nfpes_pkg::ST_OK, '0);
            job.res[3] = nfpes_pkg::mk_res(nfpes_pkg::ACT_READ, base, '0,
                                           nfpes_pkg::ST_OK, '0);
            phase_d    = PH_ERASE_POLL;
          end
        endcase
      end
    end else begin
      unique case (phase_q)
        PH_ID_VENDOR: begin
          vendor_d   = rd[15:0];
          job.count  = 3'd1;
          job.res[0] = nfpes_pkg::mk_res(nfpes_pkg::ACT_READ, base + 32'(nb), '0,
                                         nfpes_pkg::ST_OK, '0);
          phase_d    = PH_ID_DEVICE;
        end
        PH_ID_DEVICE: begin
          job.count  = 3'd2;
          job.res[0] = nfpes_pkg::mk_res(nfpes_pkg::ACT_WRITE, base,
                                         nfpes_pkg::CMD_RESET, nfpes_pkg::ST_OK, '0);
          job.res[1] = nfpes_pkg::mk_res(nfpes_pkg::ACT_DONE, '0, '0,
                                         nfpes_pkg::ST_OK, {vendor_q, rd[15:0]});
          phase_d    = PH_IDLE;
        end
        PH_PROG_POLL, PH_ERASE_POLL: begin
          if (ready) begin
            job.res[0] = nfpes_pkg::mk_res(nfpes_pkg::ACT_WRITE, base,
                                           nfpes_pkg::CMD_RESET, nfpes_pkg::ST_OK, '0);
            job.count  = 3'd2;
            if (phase_q == PH_PROG_POLL) begin
              job.res[1] = nfpes_pkg::mk_res(nfpes_pkg::ACT_READ, target_q, '0,
                                             nfpes_pkg::ST_OK, '0);
              phase_d    = PH_PROG_VERIFY;
            end else if (left_q == '0) begin
              job.res[1] = nfpes_pkg::mk_res(nfpes_pkg::ACT_DONE, '0, '0,
                                             nfpes_pkg::ST_OK, '0);
              phase_d    = PH_IDLE;
            end else begin
              job.res[1] = nfpes_pkg::mk_res(nfpes_pkg::ACT_READ, target_q, '0,
                                             nfpes_pkg::ST_OK, '0);
              phase_d    = PH_ERASE_CHECK;
            end
          end else begin
            count_d = dec;
            if (dec == '0) begin
              job.count  = 3'd2;
              job.res[0] = nfpes_pkg::mk_res(nfpes_pkg::ACT_WRITE, base,
                                             nfpes_pkg::CMD_RESET, nfpes_pkg::ST_OK, '0);
              job.res[1] = nfpes_pkg::mk_res(nfpes_pkg::ACT_DONE, '0, '0,
                                             nfpes_pkg::ST_TIMEOUT, '0);
              phase_d    = PH_IDLE;
            end else begin
              job.count  = 3'd1;
              job.res[0] = nfpes_pkg::mk_res(nfpes_pkg::ACT_READ, base, '0,
                                             nfpes_pkg::ST_OK, '0);
            end
          end
        end
        PH_PROG_VERIFY: begin
          job.count  = 3'd1;
          job.res[0] = nfpes_pkg::mk_res(nfpes_pkg::ACT_DONE, '0, '0,
                                         (rd == (expected_q & mask)) ? nfpes_pkg::ST_OK
                                                                     : nfpes_pkg::ST_VERIFY,
                                         '0);
          phase_d    = PH_IDLE;
        end
        PH_ERASE_CHECK: begin
          job.count = 3'd1;
          if (rd != mask) begin
            job.res[0] = nfpes_pkg::mk_res(nfpes_pkg::ACT_DONE, '0, '0,
                                           nfpes_pkg::ST_BLANK, '0);
            phase_d    = PH_IDLE;
          end else begin
            left_d   = left_sub;
            target_d = next_addr;
            if (left_sub == '0) begin
              job.res[0] = nfpes_pkg::mk_res(nfpes_pkg::ACT_DONE, '0, '0,
                                             nfpes_pkg::ST_OK, '0);
              phase_d    = PH_IDLE;
            end else begin
              job.res[0] = nfpes_pkg::mk_res(nfpes_pkg::ACT_READ, next_addr, '0,
                                             nfpes_pkg::ST_OK, '0);
            end
          end
        end
        default: begin
          job = '0;
        end
      endcase
    end
  end

  assign push_o = take & (job.count != 3'd0);
  assign job_o  = job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      count_q    <= '0;
      target_q   <= '0;
      expected_q <= '0;
      left_q     <= '0;
      vendor_q   <= '0;
    end else if (take) begin
      phase_q    <= phase_d;
      count_q    <= count_d;
      target_q   <= target_d;
      expected_q <= expected_d;
      left_q     <= left_d;
      vendor_q   <= vendor_d;
    end
  end

endmodule

// File: design/nfpes_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfpes_queue
// Short job queue between the front and back parts of the sequencer.
// ----------------------------------------------------------------------------
module nfpes_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  nfpes_pkg::job_t job_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output nfpes_pkg::job_t job_o
);

  localparam int unsigned PTR_W = $clog2(nfpes_pkg::QUEUE_DEPTH);

  nfpes_pkg::job_t             mem_q [nfpes_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]            wr_q, rd_q;
  logic [PTR_W:0]              fill_q;

  assign full_o  = fill_q == (PTR_W + 1)'(nfpes_pkg::QUEUE_DEPTH);
  assign empty_o = fill_q == '0;
  assign job_o   = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      fill_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PTR_W'(nfpes_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == PTR_W'(nfpes_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        fill_q <= fill_q + (PTR_W + 1)'(1);
      end else if (pop_i && !push_i) begin
        fill_q <= fill_q - (PTR_W + 1)'(1);
      end
    end
  end

endmodule

// File: design/nfpes_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfpes_back
// Holds the current job and issues one bus operation per cycle unless stalled.
// ----------------------------------------------------------------------------
module nfpes_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            empty_i,
  input  nfpes_pkg::job_t job_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output nfpes_pkg::res_t res_o,
  output logic            last_o
);

  nfpes_pkg::job_t job_q;
  logic            busy_q;
  logic [1:0]      idx_q;
  logic            fire;
  logic            done;

  assign out_valid_o = busy_q;
  assign res_o       = job_q.res[idx_q];
  assign last_o      = (3'(idx_q) + 3'd1) == job_q.count;
  assign fire        = busy_q & ~out_stall_i;
  assign done        = fire & last_o;
  assign pop_o       = ~empty_i & (~busy_q | done);

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else if (pop_o) begin
      busy_q <= 1'b1;
      idx_q  <= '0;
    end else if (done) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else if (fire) begin
      idx_q <= idx_q + 2'd1;
    end
  end

endmodule

// File: design/nor_flash_program_erase_sequencer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nor_flash_program_erase_sequencer_unit
// Host-side command sequencer for program, erase and read ID of a NOR flash.
// ----------------------------------------------------------------------------
// Each accepted item is handled in the cycle it arrives and becomes a job of
// zero to four bus operations; each job with at least one goes into a
// two-entry queue. The output side issues one operation per cycle while
// out_stall_i is low, at most four per item, and the input keeps
// accepting until the queue is full. A request that arrives while an
// operation runs and a read response that arrives while idle are dropped.
// Configuration registers take effect on the next item.
module nor_flash_program_erase_sequencer_unit #(
  parameter int unsigned MAX_SECTOR_BYTES = 262144
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  opcode_i,
  input  logic [31:0] address_i,
  input  logic [31:0] data_i,
  input  logic [18:0] sector_bytes_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  action_o,
  output logic [31:0] bus_address_o,
  output logic [31:0] bus_data_o,
  output logic [1:0]  status_o,
  output logic [31:0] chip_ident_o,
  output logic        last_o
);

  nfpes_pkg::cfg_t cfg_q;
  nfpes_pkg::job_t push_job, head_job;
  nfpes_pkg::res_t res;
  logic            push, pop, full, empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.port_width_code    <= nfpes_pkg::PW_16;
      cfg_q.base_address       <= '0;
      cfg_q.program_poll_limit <= '1;
      cfg_q.erase_poll_limit   <= '1;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        nfpes_pkg::CFG_PORT_WIDTH: cfg_q.port_width_code <= cfg_data_i[1:0];
        nfpes_pkg::CFG_BASE:       cfg_q.base_address    <= cfg_data_i;
        nfpes_pkg::CFG_PROG_LIMIT: begin
          cfg_q.program_poll_limit <= cfg_data_i[nfpes_pkg::CNT_W-1:0];
        end
        default: cfg_q.erase_poll_limit <= cfg_data_i[nfpes_pkg::CNT_W-1:0];
      endcase
    end
  end

  nfpes_front #(
    .MAX_SECTOR_BYTES(MAX_SECTOR_BYTES)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .opcode_i       (opcode_i),
    .address_i      (address_i),
    .data_i         (data_i),
    .sector_bytes_i (sector_bytes_i),
    .full_i         (full),
    .push_o         (push),
    .job_o          (push_job)
  );

  nfpes_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .job_o   (head_job)
  );

  nfpes_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .job_i       (head_job),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res),
    .last_o      (last_o)
  );

  assign action_o      = res.action;
  assign bus_address_o = res.bus_address;
  assign bus_data_o    = res.bus_data;
  assign status_o      = res.status;
  assign chip_ident_o  = res.chip_ident;

endmodule

// File: dv/nor_flash_program_erase_sequencer_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nor_flash_program_erase_sequencer_unit_tb
// Self-checking testbench for the NOR flash program/erase sequencer.
// Request and bus read response items are queued by a stimulus process and
// offered by a driver with random gaps; a receiver stalls the result side at
// random. Every accepted item runs through a cycle-free model of the command
// sequences, and each accepted result is checked against the oldest bus
// operation still due. Directed sequences cover read ID, program, erase, the
// timeout, verify and blank-check outcomes and the corner cases; random
// rounds then sweep port widths, base addresses and poll limits.
// ----------------------------------------------------------------------------
module nor_flash_program_erase_sequencer_unit_tb;

  localparam int unsigned SECTOR_CAP  = 262144;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned RANDOM_ITEMS = 110;

  typedef enum logic [2:0] {
    SEQ_IDLE, SEQ_ID_VENDOR, SEQ_ID_DEVICE, SEQ_PROG_POLL, SEQ_PROG_VERIFY,
    SEQ_ERASE_POLL, SEQ_ERASE_CHECK
  } seq_phase_e;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] addr;
    logic [31:0] data;
    logic [18:0] size;
  } flash_item_t;

  typedef struct packed {
    nfpes_pkg::res_t r;
    logic            last;
  } bus_op_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_index_i;
  logic [31:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [1:0]  opcode_i;
  logic [31:0] address_i;
  logic [31:0] data_i;
  logic [18:0] sector_bytes_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [1:0]  action_o;
  logic [31:0] bus_address_o;
  logic [31:0] bus_data_o;
  logic [1:0]  status_o;
  logic [31:0] chip_ident_o;
  logic        last_o;

  nor_flash_program_erase_sequencer_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .opcode_i      (opcode_i),
    .address_i     (address_i),
    .data_i        (data_i),
    .sector_bytes_i(sector_bytes_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .action_o      (action_o),
    .bus_address_o (bus_address_o),
    .bus_data_o    (bus_data_o),
    .status_o      (status_o),
    .chip_ident_o  (chip_ident_o),
    .last_o        (last_o)
  );

  // Shadow registers and sequence state.
  logic [1:0]  cfg_width;
  logic [31:0] cfg_base;
  logic [26:0] cfg_plimit;
  logic [26:0] cfg_elimit;
  seq_phase_e  seq;
  logic [26:0] countdown;
  logic [31:0] target;
  logic [31:0] program_word;
  logic [18:0] left;
  logic [15:0] vendor;

  bus_op_t     ops_now[$];
  bus_op_t     bus_ops_due[$];
  flash_item_t pending_items[$];
  flash_item_t cur;

  int unsigned cycles;
  int unsigned err_cnt;
  int unsigned items_queued;
  int unsigned gap_left;
  int unsigned res_wait;
  int unsigned hold_left;
  logic        offering;
  logic        item_taken;
  logic        res_taken;
  logic        hold_req;
  logic        calm;

  function automatic logic [31:0] width_bytes();
    case (cfg_width)
      nfpes_pkg::PW_8:  return 32'd1;
      nfpes_pkg::PW_16: return 32'd2;
      default:          return 32'd4;
    endcase
  endfunction

  function automatic logic [31:0] width_mask();
    case (cfg_width)
      nfpes_pkg::PW_8:  return 32'h0000_00FF;
      nfpes_pkg::PW_16: return 32'h0000_FFFF;
      default:          return 32'hFFFF_FFFF;
    endcase
  endfunction

  function automatic logic [26:0] start_count(logic [26:0] lim);
    if (lim < 27'd2) return 27'd1;
    return lim - 27'd1;
  endfunction

  function automatic void add_op(logic [1:0] act, logic [31:0] addr, logic [31:0] dat,
                                 logic [1:0] st, logic [31:0] id);
    bus_op_t o;
    o.r.action      = act;
    o.r.bus_address = addr;
    o.r.bus_data    = dat;
    o.r.status      = st;
    o.r.chip_ident  = id;
    o.last          = 1'b0;
    ops_now.push_back(o);
  endfunction

  // One status poll: returns 1 when the flash reports ready.
  function automatic logic poll_ready(logic [31:0] rd);
    if (rd[nfpes_pkg::STAT_READY_BIT]) return 1'b1;
    countdown = countdown - 27'd1;
    if (countdown == 27'd0) begin
      add_op(nfpes_pkg::ACT_WRITE, cfg_base, nfpes_pkg::CMD_RESET, '0, '0);
      add_op(nfpes_pkg::ACT_DONE, '0, '0, nfpes_pkg::ST_TIMEOUT, '0);
      seq = SEQ_IDLE;
    end else begin
      add_op(nfpes_pkg::ACT_READ, cfg_base, '0, '0, '0);
    end
    return 1'b0;
  endfunction

  task automatic derive_bus_ops(input flash_item_t it);
    logic [31:0] mask;
    logic [31:0] nb;
    logic [31:0] rd;
    bus_op_t     o;
    mask = width_mask();
    nb   = width_bytes();
    rd   = it.data & mask;
    ops_now.delete();
    if (it.op != nfpes_pkg::OP_RESPONSE) begin
      if (seq == SEQ_IDLE) begin
        case (it.op)
          nfpes_pkg::OP_READ_ID: begin
            add_op(nfpes_pkg::ACT_WRITE, cfg_base, nfpes_pkg::CMD_READ_ID, '0, '0);
            add_op(nfpes_pkg::ACT_READ, cfg_base, '0, '0, '0);
            seq = SEQ_ID_VENDOR;
          end
          nfpes_pkg::OP_PROGRAM: begin
            target       = it.addr;
            program_word = rd;
            countdown    = start_count(cfg_plimit);
            add_op(nfpes_pkg::ACT_WRITE, cfg_base, nfpes_pkg::CMD_CLEAR_STAT, '0, '0);
            add_op(nfpes_pkg::ACT_WRITE, cfg_base, nfpes_pkg::CMD_PROGRAM, '0, '0);
            add_op(nfpes_pkg::ACT_WRITE, it.addr, rd, '0, '0);
            add_op(nfpes_pkg::ACT_READ, cfg_base, '0, '0, '0);
            seq = SEQ_PROG_POLL;
          end
          default: begin
            target    = it.addr;
            left      = (it.size > SECTOR_CAP) ? 19'(SECTOR_CAP) : it.size;
            countdown = start_count(cfg_elimit);
            add_op(nfpes_pkg::ACT_WRITE, cfg_base, nfpes_pkg::CMD_CLEAR_STAT, '0, '0);
            add_op(nfpes_pkg::ACT_WRITE, cfg_base, nfpes_pkg::CMD_ERASE, '0, '0);
            add_op(nfpes_pkg::ACT_WRITE, it.addr, nfpes_pkg::CMD_CONFIRM, '0, '0);
            add_op(nfpes_pkg::ACT_READ, cfg_base, '0, '0, '0);
            seq = SEQ_ERASE_POLL;
          end
        endcase
      end
    end else begin
      case (seq)
        SEQ_ID_VENDOR: begin
          vendor = rd[15:0];
          add_op(nfpes_pkg::ACT_READ, cfg_base + nb, '0, '0, '0);
          seq = SEQ_ID_DEVICE;
        end
        SEQ_ID_DEVICE: begin
          add_op(nfpes_pkg::ACT_WRITE, cfg_base, nfpes_pkg::CMD_RESET, '0, '0);
          add_op(nfpes_pkg::ACT_DONE, '0, '0, nfpes_pkg::ST_OK, {vendor, rd[15:0]});
          seq = SEQ_IDLE;
        end
        SEQ_PROG_POLL: begin
          if (poll_ready(rd)) begin
            add_op(nfpes_pkg::ACT_WRITE, cfg_base, nfpes_pkg::CMD_RESET, '0, '0);
            add_op(nfpes_pkg::ACT_READ, target, '0, '0, '0);
            seq = SEQ_PROG_VERIFY;
          end
        end
        SEQ_PROG_VERIFY: begin
          add_op(nfpes_pkg::ACT_DONE, '0, '0,
                 (rd == (program_word & mask)) ? nfpes_pkg::ST_OK : nfpes_pkg::ST_VERIFY,
                 '0);
          seq = SEQ_IDLE;
        end
        SEQ_ERASE_POLL: begin
          if (poll_ready(rd)) begin
            add_op(nfpes_pkg::ACT_WRITE, cfg_base, nfpes_pkg::CMD_RESET, '0, '0);
            if (left == '0) begin
              add_op(nfpes_pkg::ACT_DONE, '0, '0, nfpes_pkg::ST_OK, '0);
              seq = SEQ_IDLE;
            end else begin
              add_op(nfpes_pkg::ACT_READ, target, '0, '0, '0);
              seq = SEQ_ERASE_CHECK;
            end
          end
        end
        SEQ_ERASE_CHECK: begin
          if (rd != mask) begin
            add_op(nfpes_pkg::ACT_DONE, '0, '0, nfpes_pkg::ST_BLANK, '0);
            seq = SEQ_IDLE;
          end else begin
            left   = (left <= nb) ? '0 : left - 19'(nb);
            target = target + nb;
            if (left == '0) begin
              add_op(nfpes_pkg::ACT_DONE, '0, '0, nfpes_pkg::ST_OK, '0);
              seq = SEQ_IDLE;
            end else begin
              add_op(nfpes_pkg::ACT_READ, target, '0, '0, '0);
            end
          end
        end
        default: ;
      endcase
    end
    foreach (ops_now[i]) begin
      o      = ops_now[i];
      o.last = (i == ops_now.size() - 1);
      bus_ops_due.push_back(o);
    end
  endtask

  // ---------------------------------------------------------------- clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // ----------------------------------------------- acceptance and checking
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("nor_flash_program_erase_sequencer_unit regression: fail");
      $finish;
    end
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        item_taken = 1'b1;
        derive_bus_ops(flash_item_t'{opcode_i, address_i, data_i, sector_bytes_i});
      end
      if (out_valid_o && !out_stall_i) begin
        res_taken = 1'b1;
        if (bus_ops_due.size() == 0) begin
          $error("unexpected result: action %0d address %h data %h", action_o,
                 bus_address_o, bus_data_o);
          err_cnt++;
        end else begin
          bus_op_t e;
          e = bus_ops_due.pop_front();
          if (action_o !== e.r.action) begin
            $error("action: expected %h, got %h", e.r.action, action_o);
            err_cnt++;
          end
          if (bus_address_o !== e.r.bus_address) begin
            $error("bus_address: expected %h, got %h", e.r.bus_address, bus_address_o);
            err_cnt++;
          end
          if (bus_data_o !== e.r.bus_data) begin
            $error("bus_data: expected %h, got %h", e.r.bus_data, bus_data_o);
            err_cnt++;
          end
          if (status_o !== e.r.status) begin
            $error("status: expected %h, got %h", e.r.status, status_o);
            err_cnt++;
          end
          if (chip_ident_o !== e.r.chip_ident) begin
            $error("chip_ident: expected %h, got %h", e.r.chip_ident, chip_ident_o);
            err_cnt++;
          end
          if (last_o !== e.last) begin
            $error("last: expected %h, got %h", e.last, last_o);
            err_cnt++;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------- driver
  always @(negedge clk_i) begin
    if (item_taken) begin
      item_taken = 1'b0;
      offering   = 1'b0;
      gap_left   = calm ? 0 : $urandom_range(0, 19);
    end
    if (!offering) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_items.size() > 0) begin
        cur      = pending_items.pop_front();
        offering = 1'b1;
      end
    end
    in_valid_i     <= offering;
    opcode_i       <= cur.op;
    address_i      <= cur.addr;
    data_i         <= cur.data;
    sector_bytes_i <= cur.size;
  end

  // -------------------------------------------------------------- receiver
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (res_taken) begin
      res_taken = 1'b0;
      res_wait  = calm ? 0 : $urandom_range(0, 19);
    end else if (res_wait > 0) begin
      res_wait--;
    end
    if (hold_left > 0) hold_left--;
    out_stall_i <= (hold_left > 0) || (res_wait > 0);
  end

  // -------------------------------------------------------------- stimulus
  task automatic push_item(input logic [1:0] op, input logic [31:0] addr,
                           input logic [31:0] data, input logic [18:0] size);
    pending_items.push_back('{op, addr, data, size});
    items_queued++;
  endtask

  task automatic push_response(input logic [31:0] data);
    push_item(nfpes_pkg::OP_RESPONSE, $urandom, data, 19'($urandom));
  endtask

  function automatic logic [31:0] poll_word(logic ready);
    logic [31:0] w;
    w = $urandom;
    w[nfpes_pkg::STAT_READY_BIT] = ready;
    return w;
  endfunction

  function automatic logic [31:0] fill_word(logic [31:0] low);
    return ($urandom & ~width_mask()) | (low & width_mask());
  endfunction

  function automatic logic [31:0] flip_port_bit(logic [31:0] w);
    return w ^ (32'd1 << $urandom_range(0, 8 * width_bytes() - 1));
  endfunction

  task automatic plan_read_id(input logic interrupt);
    push_item(nfpes_pkg::OP_READ_ID, $urandom, $urandom, 19'($urandom));
    if (interrupt) push_item(2'($urandom_range(0, 2)), $urandom, $urandom, 19'($urandom));
    push_response($urandom);
    push_response($urandom);
  endtask

  task automatic plan_program(input logic [31:0] addr, input logic [31:0] word,
                              input int busy, input logic good);
    int polls;
    polls = int'(start_count(cfg_plimit));
    push_item(nfpes_pkg::OP_PROGRAM, addr, word, 19'($urandom));
    for (int i = 0; i < busy && i < polls; i++) push_response(poll_word(1'b0));
    if (busy >= polls) return;
    push_response(poll_word(1'b1));
    push_response(fill_word(good ? word : flip_port_bit(word)));
  endtask

  task automatic plan_erase(input logic [31:0] addr, input logic [18:0] size,
                            input int busy, input logic good);
    int polls;
    int nb;
    int words;
    int fail_at;
    polls = int'(start_count(cfg_elimit));
    nb    = int'(width_bytes());
    words = ((size > SECTOR_CAP ? SECTOR_CAP : int'(size)) + nb - 1) / nb;
    if (words > 32) good = 1'b0;
    fail_at = (good || words == 0) ? words : $urandom_range(0, (words > 8) ? 7 : words - 1);
    push_item(nfpes_pkg::OP_ERASE, addr, $urandom, size);
    for (int i = 0; i < busy && i < polls; i++) push_response(poll_word(1'b0));
    if (busy >= polls) return;
    push_response(poll_word(1'b1));
    for (int i = 0; i < words; i++) begin
      if (i == fail_at) begin
        push_response(fill_word(flip_port_bit(width_mask())));
        return;
      end
      push_response(fill_word(width_mask()));
    end
  endtask

  // Waits until every item is taken and every result is back, then answers
  // any sequence left open until the sequencer is idle again.
  task automatic settle();
    while (1) begin
      while (pending_items.size() != 0 || offering) @(posedge clk_i);
      while (bus_ops_due.size() != 0) @(posedge clk_i);
      repeat (16) @(posedge clk_i);
      if (seq == SEQ_IDLE) break;
      case (seq)
        SEQ_PROG_POLL, SEQ_ERASE_POLL: push_response(poll_word(1'b1));
        SEQ_ERASE_CHECK:               push_response(32'h0);
        default:                       push_response($urandom);
      endcase
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      nfpes_pkg::CFG_PORT_WIDTH: cfg_width  = val[1:0];
      nfpes_pkg::CFG_BASE:       cfg_base   = val;
      nfpes_pkg::CFG_PROG_LIMIT: cfg_plimit = val[26:0];
      default:                   cfg_elimit = val[26:0];
    endcase
  endtask

  task automatic new_setting(input logic [31:0] width, input logic [31:0] base,
                             input logic [31:0] plim, input logic [31:0] elim);
    settle();
    write_reg(nfpes_pkg::CFG_PORT_WIDTH, width);
    write_reg(nfpes_pkg::CFG_BASE, base);
    write_reg(nfpes_pkg::CFG_PROG_LIMIT, plim);
    write_reg(nfpes_pkg::CFG_ERASE_LIMIT, elim);
  endtask

  function automatic logic [31:0] pick_limit();
    case ($urandom_range(0, 9))
      0:       return 32'($urandom_range(0, 1));
      1:       return 32'h07FF_FFFF;
      default: return 32'($urandom_range(2, 8));
    endcase
  endfunction

  function automatic logic [31:0] pick_base();
    case ($urandom_range(0, 3))
      0:       return 32'h0;
      1:       return 32'hFFFF_FFFF - 32'($urandom_range(0, 4));
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int unsigned start;
    int          pick;
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_index_i    = nfpes_pkg::CFG_PORT_WIDTH;
    cfg_data_i     = '0;
    in_valid_i     = 1'b0;
    opcode_i       = nfpes_pkg::OP_READ_ID;
    address_i      = '0;
    data_i         = '0;
    sector_bytes_i = '0;
    out_stall_i    = 1'b0;
    cur            = '0;
    cycles         = 0;
    err_cnt        = 0;
    items_queued   = 0;
    gap_left       = 0;
    res_wait       = 0;
    hold_left      = 0;
    offering       = 1'b0;
    item_taken     = 1'b0;
    res_taken      = 1'b0;
    hold_req       = 1'b0;
    calm           = 1'b0;
    cfg_width      = nfpes_pkg::PW_16;
    cfg_base       = '0;
    cfg_plimit     = '1;
    cfg_elimit     = '1;
    seq            = SEQ_IDLE;
    countdown      = '0;
    target         = '0;
    program_word   = '0;
    left           = '0;
    vendor         = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Settings after reset: 16-bit port, base zero, longest poll limits.
    plan_read_id(1'b0);
    plan_read_id(1'b1);
    plan_program(32'h0000_1000, 32'hFFFF_FFFF, 2, 1'b1);
    plan_program(32'hFFFF_FFFE, 32'h0000_0000, 0, 1'b0);
    plan_erase(32'h0002_0000, 19'd0, 1, 1'b1);
    plan_erase(32'h0003_0000, 19'd3, 0, 1'b1);
    plan_erase(32'h0004_0000, 19'd6, 0, 1'b0);
    plan_erase(32'h0000_0000, 19'h7FFFF, 0, 1'b0);
    push_response(32'hFFFF_FFFF);

    // Byte port at the top of the address space; poll limits of two and three.
    new_setting({30'($urandom), nfpes_pkg::PW_8}, 32'hFFFF_FFFF, 32'd2, 32'd3);
    plan_read_id(1'b0);
    plan_program($urandom, $urandom, 1, 1'b1);
    plan_erase($urandom, 19'd4, 2, 1'b1);
    plan_program($urandom, $urandom, 0, 1'b1);
    plan_erase(32'hFFFF_FFFE, 19'd4, 1, 1'b1);

    // Width code three acts as a 32-bit port; limits below two act as two.
    new_setting(32'd3, 32'h8000_0000, 32'd0, 32'd1);
    plan_program($urandom, $urandom, 1, 1'b1);
    plan_erase($urandom, 19'd9, 0, 1'b1);
    plan_read_id(1'b0);
    plan_program($urandom, $urandom, 0, 1'b0);

    // Limit bits above the counter width are dropped.
    new_setting(32'd2, $urandom, 32'hFFFF_FFFF, 32'hF800_0005);
    plan_program($urandom, $urandom, 3, 1'b1);
    plan_erase($urandom, 19'd8, 4, 1'b1);
    settle();
    @(posedge clk_i);
    hold_req = 1'b1;
    plan_program($urandom, $urandom, 12, 1'b1);
    plan_read_id(1'b0);

    start = items_queued;
    while (items_queued - start < RANDOM_ITEMS) begin
      new_setting($urandom_range(0, 3) == 0 ? $urandom : 32'($urandom_range(0, 3)),
                  pick_base(), pick_limit(), pick_limit());
      calm = ($urandom_range(0, 3) == 0);
      repeat (6) begin
        pick = $urandom_range(0, 19);
        if (pick < 6) begin
          plan_program($urandom, $urandom, $urandom_range(0, 3), $urandom_range(0, 3) != 0);
        end else if (pick < 12) begin
          plan_erase($urandom,
                     ($urandom_range(0, 11) == 0) ? 19'($urandom) : 19'($urandom_range(0, 24)),
                     $urandom_range(0, 3), $urandom_range(0, 3) != 0);
        end else if (pick < 15) begin
          plan_read_id($urandom_range(0, 3) == 0);
        end else begin
          push_item(2'($urandom), $urandom, $urandom, 19'($urandom));
          settle();
        end
      end
    end

    settle();
    calm = 1'b0;
    if (err_cnt == 0 && bus_ops_due.size() == 0) begin
      $display("nor_flash_program_erase_sequencer_unit regression: pass");
    end else begin
      $display("nor_flash_program_erase_sequencer_unit regression: fail");
    end
    $finish;
  end

endmodule
